// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files (included by e2a_back)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante
`define E2A_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante
`define E2A_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/e2a_pkg.sv
// Types and constants of the Euler-angle to axis-vector block
package e2a_pkg;

  localparam int FRAC = 28;
  localparam logic signed [31:0] PI_Q      = 32'sd843314857;
  localparam logic signed [31:0] HALF_PI_Q = 32'sd421657428;
  localparam logic [28:0]        ONE_Q     = 29'd268435456;

  localparam int STEPS = 3;
  localparam int unsigned SIN_DIV [STEPS+1] = '{72, 42, 20, 6};
  localparam int unsigned COS_DIV [STEPS+1] = '{90, 56, 30, 12};

  localparam int SC_LAT = 2 * STEPS + 4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] ROW_RIGHT = 2'd0;
  localparam logic [1:0] ROW_UP    = 2'd1;
  localparam logic [1:0] ROW_FWD   = 2'd2;

  typedef logic signed [29:0] ang_t;
  typedef logic signed [30:0] trig_t;

  typedef struct packed {
    ang_t       ax;
    ang_t       ay;
    ang_t       az;
    logic [2:0] flip;
    logic [1:0] row;
  } item_t;

endpackage

// File: hw/rtl/e2a_front.sv
// Front end: scale the angles, negate X and Z, range-reduce them, map the selector
module e2a_front import e2a_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  logic signed [ANGLE_BITS-1:0] angle_x,
  input  logic signed [ANGLE_BITS-1:0] angle_y,
  input  logic signed [ANGLE_BITS-1:0] angle_z,
  input  logic [1:0]                   axis_select,
  output item_t                        item
);

  localparam int SH = 31 - ANGLE_BITS;

  function automatic logic [30:0] reduce(input logic signed [31:0] a);
    logic signed [31:0] r;
    logic               f;
    r = a;
    f = 1'b0;
    if (a > HALF_PI_Q) begin
      r = a - PI_Q;
      f = 1'b1;
    end else if (a < -HALF_PI_Q) begin
      r = a + PI_Q;
      f = 1'b1;
    end
    return {f, r[29:0]};
  endfunction

  logic signed [31:0] qx, qy, qz;
  logic [30:0]        rx, ry, rz;

  always_comb begin
    qx = -(32'(angle_x) <<< SH);
    qy = 32'(angle_y) <<< SH;
    qz = -(32'(angle_z) <<< SH);
    rx = reduce(qx);
    ry = reduce(qy);
    rz = reduce(qz);
    item.ax   = rx[29:0];
    item.ay   = ry[29:0];
    item.az   = rz[29:0];
    item.flip = {rz[30], ry[30], rx[30]};
    item.row  = (axis_select > ROW_FWD) ? ROW_FWD : axis_select;
  end

endmodule

// File: hw/rtl/e2a_fifo.sv
// Short queue between front and back end
module e2a_fifo import e2a_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_data,
  output logic  pop_valid,
  input  logic  pop,
  output item_t pop_data
);

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_r + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end
  end

endmodule

// File: hw/rtl/e2a_sincos.sv
// Pipelined polynomial sine and cosine of a reduced Q28 angle
module e2a_sincos import e2a_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  ang_t  a_i,
  input  logic  flip_i,
  output trig_t sin_o,
  output trig_t cos_o
);

  localparam int CH = 2 * STEPS;

  logic signed [59:0] sq_w;
  logic [57:0]        sq_r;
  ang_t               a1_r;
  logic               f1_r;
  logic [29:0]        s2_r [CH+1];
  ang_t               a_r  [CH+1];
  logic               f_r  [CH+1];
  logic [62:0]        qs_r [STEPS+1];
  logic [62:0]        qc_r [STEPS+1];
  logic [58:0]        ps_r [STEPS];
  logic [58:0]        pc_r [STEPS];
  logic [31:0]        mul_s [STEPS+1];
  logic [31:0]        mul_c [STEPS+1];
  logic [28:0]        ts [STEPS+1];
  logic [28:0]        tc [STEPS+1];
  logic signed [59:0] ms_r;
  logic [58:0]        pcf_r;
  logic               ff_r;
  trig_t              s_w, c_w, sin_r, cos_r;

  assign sq_w = a_i * a_i;

  for (genvar k = 0; k <= STEPS; k++) begin : g_rcp
    localparam int LS = $clog2(SIN_DIV[k]);
    localparam int LC = $clog2(COS_DIV[k]);
    localparam logic [31:0] MS =
      32'(((64'd1 << (31 + LS)) + 64'(SIN_DIV[k]) - 64'd1) / 64'(SIN_DIV[k]));
    localparam logic [31:0] MC =
      32'(((64'd1 << (31 + LC)) + 64'(COS_DIV[k]) - 64'd1) / 64'(COS_DIV[k]));
    assign mul_s[k] = MS;
    assign mul_c[k] = MC;
    assign ts[k]    = ONE_Q - 29'(qs_r[k] >> (31 + LS));
    assign tc[k]    = ONE_Q - 29'(qc_r[k] >> (31 + LC));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r    <= sq_w[57:0];
      a1_r    <= a_i;
      f1_r    <= flip_i;
      s2_r[0] <= sq_r[57:28];
      a_r[0]  <= a1_r;
      f_r[0]  <= f1_r;
      qs_r[0] <= sq_r[57:28] * mul_s[0];
      qc_r[0] <= sq_r[57:28] * mul_c[0];
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        ps_r[k]       <= s2_r[2*k] * ts[k];
        pc_r[k]       <= s2_r[2*k] * tc[k];
        s2_r[2*k+1]   <= s2_r[2*k];
        a_r[2*k+1]    <= a_r[2*k];
        f_r[2*k+1]    <= f_r[2*k];
        qs_r[k+1]     <= ps_r[k][58:28] * mul_s[k+1];
        qc_r[k+1]     <= pc_r[k][58:28] * mul_c[k+1];
        s2_r[2*k+2]   <= s2_r[2*k+1];
        a_r[2*k+2]    <= a_r[2*k+1];
        f_r[2*k+2]    <= f_r[2*k+1];
      end
    end
  end

  assign s_w = ms_r[58:28];
  assign c_w = trig_t'(ONE_Q) - trig_t'(pcf_r[58:29]);

  always_ff @(posedge clk) begin
    if (en) begin
      ms_r  <= a_r[CH] * $signed({1'b0, ts[STEPS]});
      pcf_r <= s2_r[CH] * tc[STEPS];
      ff_r  <= f_r[CH];
      sin_r <= ff_r ? -s_w : s_w;
      cos_r <= ff_r ? -c_w : c_w;
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

// File: hw/rtl/e2a_back.sv
// Back end: sine/cosine units, row of the rotation product, rounding and saturation
`include "assert_macros.svh"
module e2a_back import e2a_pkg::*; #(
  parameter int OUT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       item_valid,
  input  item_t                      item,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OUT_BITS-1:0] dir_first,
  output logic signed [OUT_BITS-1:0] dir_second,
  output logic signed [OUT_BITS-1:0] dir_third
);

  localparam int TOT = SC_LAT + 5;
  localparam int FO  = OUT_BITS - 2;
  localparam logic signed [32:0] RND = 33'sd1 <<< (27 - FO);
  localparam logic signed [32:0] LIM = 33'sd1 <<< FO;
  localparam logic signed [OUT_BITS-1:0] LIM_O = OUT_BITS'(LIM);

  function automatic logic [OUT_BITS-1:0] to_out(input logic signed [31:0] q);
    logic signed [32:0] r;
    logic signed [32:0] v;
    r = $signed({q[31], q}) + RND;
    v = r >>> (28 - FO);
    if (v > LIM) begin
      v = LIM;
    end else if (v < -LIM) begin
      v = -LIM;
    end
    return v[OUT_BITS-1:0];
  endfunction

  logic [TOT-1:0] v_r;
  logic           en;
  logic [1:0]     rowp_r [SC_LAT];
  trig_t          sx, cx, sy, cy, sz, cz;

  trig_t              cx1_r, sx1_r, cy1_r, sy1_r, sz1_r, cz1_r;
  logic [1:0]         row1_r;
  logic signed [61:0] sxsy_r, sxcy_r, cxsy_r, cxcy_r;
  trig_t              p0, p1, p2;
  trig_t              p0_r, p1_r, p2_r, sz2_r, cz2_r;
  logic signed [61:0] m00_r, m01_r, m10_r, m11_r;
  trig_t              p2b_r;
  logic signed [62:0] sum0, sum1;
  logic signed [31:0] e0_r, e1_r, e2_r;
  logic [OUT_BITS-1:0] first_r, second_r, third_r;
  logic                rng_ok;

  assign en        = !v_r[TOT-1] || out_ready;
  assign pop       = en && item_valid;
  assign out_valid = v_r[TOT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[TOT-2:0], item_valid};
    end
  end

  e2a_sincos u_sc_x (
    .clk(clk), .en(en), .a_i(item.ax), .flip_i(item.flip[0]), .sin_o(sx), .cos_o(cx)
  );
  e2a_sincos u_sc_y (
    .clk(clk), .en(en), .a_i(item.ay), .flip_i(item.flip[1]), .sin_o(sy), .cos_o(cy)
  );
  e2a_sincos u_sc_z (
    .clk(clk), .en(en), .a_i(item.az), .flip_i(item.flip[2]), .sin_o(sz), .cos_o(cz)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      rowp_r[0] <= item.row;
      for (int i = 1; i < SC_LAT; i++) begin
        rowp_r[i] <= rowp_r[i-1];
      end
    end
  end

  always_comb begin
    unique case (row1_r)
      ROW_RIGHT: begin
        p0 = cy1_r;
        p1 = '0;
        p2 = -sy1_r;
      end
      ROW_UP: begin
        p0 = sxsy_r[58:28];
        p1 = cx1_r;
        p2 = sxcy_r[58:28];
      end
      default: begin
        p0 = cxsy_r[58:28];
        p1 = -sx1_r;
        p2 = cxcy_r[58:28];
      end
    endcase
  end

  assign sum0 = 63'(m00_r) - 63'(m01_r);
  assign sum1 = 63'(m10_r) + 63'(m11_r);

  always_ff @(posedge clk) begin
    if (en) begin
      sxsy_r   <= sx * sy;
      sxcy_r   <= sx * cy;
      cxsy_r   <= cx * sy;
      cxcy_r   <= cx * cy;
      cx1_r    <= cx;
      sx1_r    <= sx;
      cy1_r    <= cy;
      sy1_r    <= sy;
      sz1_r    <= sz;
      cz1_r    <= cz;
      row1_r   <= rowp_r[SC_LAT-1];
      p0_r     <= p0;
      p1_r     <= p1;
      p2_r     <= p2;
      sz2_r    <= sz1_r;
      cz2_r    <= cz1_r;
      m00_r    <= p0_r * cz2_r;
      m01_r    <= p1_r * sz2_r;
      m10_r    <= p0_r * sz2_r;
      m11_r    <= p1_r * cz2_r;
      p2b_r    <= p2_r;
      e0_r     <= sum0[59:28];
      e1_r     <= sum1[59:28];
      e2_r     <= 32'(p2b_r);
      first_r  <= to_out(e2_r);
      second_r <= to_out(e1_r);
      third_r  <= to_out(e0_r);
    end
  end

  assign dir_first  = first_r;
  assign dir_second = second_r;
  assign dir_third  = third_r;

  always_comb begin
    rng_ok = ($signed(first_r) <= LIM_O) && ($signed(first_r) >= -LIM_O) &&
             ($signed(second_r) <= LIM_O) && ($signed(second_r) >= -LIM_O) &&
             ($signed(third_r) <= LIM_O) && ($signed(third_r) >= -LIM_O);
  end

  `E2A_ASSERT_NEXT(a_hold, !en, $stable(v_r), "back pipeline moved while stalled")
  `E2A_ASSERT_NEXT(a_adv, en && v_r[TOT-2], v_r[TOT-1], "result lost at output stage")
  `E2A_ASSERT_IMPL(a_rng, v_r[TOT-1], rng_ok, "output beyond unit range")
  `E2A_ASSERT_IMPL(a_row, v_r[SC_LAT], row1_r == ROW_RIGHT || row1_r == ROW_UP || row1_r == ROW_FWD, "bad row code")

endmodule

// File: hw/rtl/euler_to_axis_vector_top.sv
// Top level: Euler XYZ angles in, one rotation-matrix row out
//
//  channel | dir | tdata (low bit up)               | tuser
//  in_     | in  | angle_x, angle_y, angle_z        | axis_select
//  out_    | out | dir_first, dir_second, dir_third | -
//
// One beat accepted per cycle while the queue is not full; a result passes the queue, then the back pipeline.
// Three sine/cosine units, each a 10-stage multiply chain, set the latency.
// A 4-entry queue splits front and back; in_tready drops only when it is full.
// An out_tready stall freezes the whole back pipeline. Reset clears valids and queue pointers only.
module euler_to_axis_vector_top import e2a_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int OUT_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((3*ANGLE_BITS+7)/8)*8-1:0]   in_tdata,  // angle_x, angle_y, angle_z
  input  logic [1:0]                          in_tuser,  // axis_select
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [((3*OUT_BITS+7)/8)*8-1:0]     out_tdata  // dir_first, dir_second, dir_third
);

  localparam int OUT_W = ((3*OUT_BITS+7)/8)*8;

  logic signed [ANGLE_BITS-1:0] angle_x, angle_y, angle_z;
  logic signed [OUT_BITS-1:0]   dir_first, dir_second, dir_third;
  item_t                        front_item, q_item;
  logic                         q_valid, q_pop;

  assign angle_x = in_tdata[ANGLE_BITS-1:0];
  assign angle_y = in_tdata[2*ANGLE_BITS-1:ANGLE_BITS];
  assign angle_z = in_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS];

  e2a_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
    .axis_select(in_tuser), .item(front_item)
  );

  e2a_fifo u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(in_tvalid), .push_ready(in_tready), .push_data(front_item),
    .pop_valid(q_valid), .pop(q_pop), .pop_data(q_item)
  );

  e2a_back #(.OUT_BITS(OUT_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .item_valid(q_valid), .item(q_item), .pop(q_pop),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .dir_first(dir_first), .dir_second(dir_second), .dir_third(dir_third)
  );

  assign out_tdata = OUT_W'({dir_third, dir_second, dir_first});

endmodule
